/* hdl/aes_pkg.sv */
// AES-128 package: types, constants, S-box functions and GF(2^8) helpers.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumWords  = 4 * (NumRounds + 1);
  localparam logic [7:0]  Rcon1     = 8'h01;

  typedef logic [$clog2(NumRounds+1)-1:0] round_t;
  typedef logic [$clog2(NumWords)-1:0]    widx_t;

  typedef enum logic [1:0] {
    CfgKeyHigh = 2'd0,
    CfgKeyLow  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    StIdle,
    StExpand,
    StFetch,
    StRound,
    StDone
  } state_t;

  // Request from the sequencer to the round datapath.
  typedef struct packed {
    logic   load;
    logic   step;
    logic   dec;
    logic   first;
    logic   last;
  } rnd_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

/* hdl/aes_key_sched.sv */
// AES-128 key schedule: expands one word a cycle into the round-key memory.
module aes_key_sched import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] key,
  input  widx_t        rd_addr,
  output logic [31:0]  rd_data,
  output logic         busy
);

  logic [31:0] mem [NumWords];
  widx_t       widx;
  logic [31:0] w1, w2, w3, w4;   // last four words written, w1 newest
  logic [7:0]  rc;
  logic [31:0] t, wnew;

  always_comb begin
    t = w1;
    if (widx[1:0] == 2'd0) begin
      t = sub_word({w1[23:0], w1[31:24]}) ^ {rc, 24'h0};
    end
    wnew = w4 ^ t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      widx <= '0;
      rc   <= Rcon1;
    end else if (start) begin
      busy <= 1'b1;
      widx <= widx_t'(4);
      rc   <= Rcon1;
    end else if (busy) begin
      if (widx[1:0] == 2'd0) begin
        rc <= xtime(rc);
      end
      if (widx == widx_t'(NumWords - 1)) begin
        busy <= 1'b0;
      end
      widx <= widx + widx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      {w4, w3, w2, w1} <= key;
    end else if (busy) begin
      {w4, w3, w2, w1} <= {w3, w2, w1, wnew};
    end
  end

  // Key words 0..3 are written from the key at start; words 4..43 while the schedule runs.
  always_ff @(posedge clk) begin
    if (start) begin
      mem[0] <= key[127:96];
      mem[1] <= key[95:64];
      mem[2] <= key[63:32];
      mem[3] <= key[31:0];
    end else if (busy) begin
      mem[widx] <= wnew;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/aes_round.sv */
// AES round datapath: one encrypt or decrypt round per step on the state register.
module aes_round import aes_pkg::*; (
  input  logic         clk,
  input  rnd_ctl_t     ctl,
  input  logic [127:0] blk_in,
  input  logic [127:0] rkey,
  output logic [127:0] state
);

  logic [7:0]   s [16];
  logic [7:0]   sr [16];
  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [127:0] pre, post, nxt;

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return (b[0] ? a : 8'h0) ^ (b[1] ? a2 : 8'h0) ^ (b[2] ? a4 : 8'h0) ^ (b[3] ? a8 : 8'h0);
  endfunction

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state[127-8*i -: 8];
    end
    // Encrypt: shift, sub, mix, add key. Decrypt: shift, sub, add key, mix.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.dec) begin
          sr[4*((c+r)%4)+r] = s[4*c+r];
        end else begin
          sr[4*c+r] = s[4*((c+r)%4)+r];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = ctl.dec ? ISBOX[sr[i]] : SBOX[sr[i]];
    end
    for (int i = 0; i < 16; i++) begin
      pre[127-8*i -: 8] = sb[i];
    end
    if (ctl.dec) begin
      pre = pre ^ rkey;
    end
    for (int i = 0; i < 16; i++) begin
      s[i] = pre[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.dec) begin
          mx[4*c+r] = gm(s[4*c+r], 4'd14) ^ gm(s[4*c+(r+1)%4], 4'd11)
                    ^ gm(s[4*c+(r+2)%4], 4'd13) ^ gm(s[4*c+(r+3)%4], 4'd9);
        end else begin
          mx[4*c+r] = gm(s[4*c+r], 4'd2) ^ gm(s[4*c+(r+1)%4], 4'd3)
                    ^ s[4*c+(r+2)%4] ^ s[4*c+(r+3)%4];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      post[127-8*i -: 8] = mx[i];
    end
    if (ctl.last) begin
      post = pre;
    end
    nxt = ctl.dec ? post : (post ^ rkey);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      state <= blk_in;
    end else if (ctl.first) begin
      state <= state ^ rkey;
    end else if (ctl.step) begin
      state <= nxt;
    end
  end

endmodule

/* hdl/aes128_block_cipher.sv */
// AES-128 block cipher top level: sequencer, key schedule and round datapath.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------
//  cfg      | in        | cfg_valid/ready   | cfg_index, cfg_data (key_high/low)
//  in       | in        | in_valid/in_stall | operation, block_high, block_low
//  out      | out       | out_valid/stall   | result_high, result_low
//
// A block runs on the shared round unit: for each of the eleven key additions, the
// sequencer fetches the round key (four words through the registered single-port
// memory read, the last word landing from the read register) and then applies it.
// The result is presented in the done state; with no output stall the next beat can
// be taken once the block has gone from the done state back to the idle state.
// After reset and after each key write the schedule is started by the restart pulse
// and runs until its last word is written, during which no beat is accepted;
// configuration is taken only while idle. A held result stalls the block until the beat is taken.
module aes128_block_cipher import aes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);

  state_t       state, state_next;
  logic [63:0]  key_high, key_low;
  logic         kick;          // restart the key schedule
  logic         ks_busy;
  logic [31:0]  rk_word;
  logic [127:0] rkey;
  logic [1:0]   col;           // word within the round key being fetched
  round_t       rnd;           // rounds done
  logic         dec;
  logic         rkey_ok;
  rnd_ctl_t     ctl;
  logic [127:0] blk;
  widx_t        rd_addr;
  round_t       key_rnd;

  // Hold one restart pulse after reset so the zero key gets expanded.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      kick     <= 1'b1;
    end else begin
      kick <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'({1'b0, cfg_index}))
          CfgKeyHigh: key_high <= cfg_data;
          default:    key_low  <= cfg_data;
        endcase
      end
    end
  end

  assign cfg_ready = (state == StIdle) && !kick && !ks_busy;

  aes_key_sched u_ks (
    .clk     (clk),
    .rst     (rst),
    .start   (kick),
    .key     ({key_high, key_low}),
    .rd_addr (rd_addr),
    .rd_data (rk_word),
    .busy    (ks_busy)
  );

  // Key round for the next fetch: encrypt counts up, decrypt down from ten.
  assign key_rnd = dec ? round_t'(NumRounds) - rnd : rnd;
  assign rd_addr = widx_t'({key_rnd, col});

  always_comb begin
    state_next = state;
    unique case (state)
      StIdle:   if (in_valid && !in_stall) state_next = StFetch;
      StFetch:  if (rkey_ok) state_next = StRound;
      StRound:  if (rnd == round_t'(NumRounds)) state_next = StDone;
                else state_next = StFetch;
      StDone:   if (!out_stall) state_next = StIdle;
      default:  state_next = StIdle;
    endcase
  end

  always_comb begin
    in_stall  = !(state == StIdle) || kick || ks_busy;
    out_valid = (state == StDone);
    ctl.load  = (state == StIdle) && in_valid && !in_stall;
    ctl.dec   = dec;
    ctl.first = (state == StRound) && (rnd == '0);
    ctl.step  = (state == StRound);
    ctl.last  = (rnd == round_t'(NumRounds));
  end

  assign blk = {block_high, block_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  // Fetch four words through the registered memory read, then round.
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      rnd     <= '0;
      rkey_ok <= 1'b0;
      dec     <= 1'b0;
    end else begin
      if (ctl.load) begin
        dec <= operation;
        rnd <= '0;
        col <= '0;
        rkey_ok <= 1'b0;
      end else if (state == StFetch) begin
        col <= col + 2'd1;
        if (col == 2'd0 && rkey_ok) begin
          rkey_ok <= 1'b0;
        end else if (col == 2'd3) begin
          rkey_ok <= 1'b1;
        end
      end else if (state == StRound) begin
        // hold the count at ten once the last round is done
        if (rnd != round_t'(NumRounds)) begin
          rnd <= rnd + round_t'(1);
        end
        rkey_ok <= 1'b0;
        col     <= '0;
      end
    end
  end

  // Word arriving now belongs to the column requested last cycle.
  always_ff @(posedge clk) begin
    if (state == StFetch) begin
      rkey <= {rkey[95:0], rk_word};
    end
  end

  aes_round u_round (
    .clk    (clk),
    .ctl    (ctl),
    .blk_in (blk),
    .rkey   (rkey),
    .state  ({result_high, result_low})
  );

`ifndef ASSERT_OFF
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (state != StIdle) |-> !cfg_ready) else $error("config taken while busy");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    rnd <= round_t'(NumRounds)) else $error("round count overrun");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_high))) else $error("result lost");
`endif

endmodule

/* sim/aes128_block_cipher_test.sv */
// Testbench for the AES-128 block cipher: directed and random beats checked against a behavioural cipher.
`timescale 1ns / 100ps

module aes128_block_cipher_test;
  import aes_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] result_high;
  logic [63:0] result_low;

  typedef struct packed {
    logic        dec;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_beat_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_out_t;

  aes128_block_cipher i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .operation, .block_high, .block_low,
    .out_valid, .out_stall, .result_high, .result_low
  );

  // Key held by the predictor and its expanded schedule.
  logic [63:0] model_key_hi, model_key_lo;
  logic [31:0] sched [44];
  logic [7:0]  fwd_sbox [256];
  logic [7:0]  rev_sbox [256];

  block_beat_t pending_blocks [$];
  cipher_out_t expected_blocks [$];
  int          fail_count;
  int          hold_off;       // long receiver hold-off, counted in the monitor

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---- GF(2^8) arithmetic and S-box generation ----
  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // Build both substitution tables from the field inverse and the affine map.
  task automatic build_sboxes();
    logic [7:0] r, b;
    for (int x = 0; x < 256; x++) begin
      r = 8'h01;
      b = x[7:0];
      for (int e = 0; e < 8; e++) begin
        if ((254 >> e) & 1) r = gf_mul(r, b);
        b = gf_mul(b, b);
      end
      b = r ^ rotl(r, 1) ^ rotl(r, 2) ^ rotl(r, 3) ^ rotl(r, 4) ^ 8'h63;
      fwd_sbox[x] = b;
      rev_sbox[b] = x[7:0];
    end
  endtask

  task automatic expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched[0] = model_key_hi[63:32];
    sched[1] = model_key_hi[31:0];
    sched[2] = model_key_lo[63:32];
    sched[3] = model_key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sbox[t[31:24]] ^ rc, fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
        rc = gf_dbl(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endtask

  // State byte 4*c+r is block byte 4*c+r; byte 0 is the most significant.
  function automatic cipher_out_t aes_transform(block_beat_t blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [4];
    logic [7:0] acc;
    logic [127:0] w;
    int rnd;
    w = {blk.hi, blk.lo};
    for (int i = 0; i < 16; i++) s[i] = w[127 - 8*i -: 8];
    for (int step = 0; step <= 10; step++) begin
      rnd = blk.dec ? 10 - step : step;
      if (step > 0) begin
        t = s;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            if (blk.dec) s[4*((c+r)%4)+r] = rev_sbox[t[4*c+r]];
            else s[4*c+r] = fwd_sbox[t[4*((c+r)%4)+r]];
        // forward mixing comes before the key, inverse mixing after it
        if (!blk.dec && step != 10) begin
          m = '{8'd2, 8'd3, 8'd1, 8'd1};
          t = s;
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
              acc = 8'h00;
              for (int k = 0; k < 4; k++) acc ^= gf_mul(m[(k - r + 4) % 4], t[4*c+k]);
              s[4*c+r] = acc;
            end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4*c+r] ^= sched[4*rnd+c][31 - 8*r -: 8];
      if (blk.dec && step > 0 && step != 10) begin
        m = '{8'd14, 8'd11, 8'd13, 8'd9};
        t = s;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            acc = 8'h00;
            for (int k = 0; k < 4; k++) acc ^= gf_mul(m[(k - r + 4) % 4], t[4*c+k]);
            s[4*c+r] = acc;
          end
      end
    end
    for (int i = 0; i < 16; i++) w[127 - 8*i -: 8] = s[i];
    return '{hi: w[127:64], lo: w[63:0]};
  endfunction

  // ---- driver: takes beats from the pending queue, with random gaps ----
  int gap_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      // beat taken: draw the next gap
      void'(pending_blocks.pop_front());
      expected_blocks.push_back(aes_transform(
        '{dec: operation, hi: block_high, lo: block_low}));
      gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap_left == 0 && pending_blocks.size() > 0 && $urandom_range(0, 1)) begin
        in_valid   <= 1'b1;
        operation  <= pending_blocks[0].dec;
        block_high <= pending_blocks[0].hi;
        block_low  <= pending_blocks[0].lo;
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_blocks.size() > 0) begin
        in_valid   <= 1'b1;
        operation  <= pending_blocks[0].dec;
        block_high <= pending_blocks[0].hi;
        block_low  <= pending_blocks[0].lo;
      end
    end
  end

  // ---- monitor: random stall, compare each result with the oldest expectation ----
  int stall_left;
  cipher_out_t want;
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $error("result with nothing expected: %h %h", result_high, result_low);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (result_high !== want.hi) begin
            $error("result_high expected %h actual %h", want.hi, result_high);
            fail_count++;
          end
          if (result_low !== want.lo) begin
            $error("result_low expected %h actual %h", want.lo, result_low);
            fail_count++;
          end
        end
      end
      // a requested hold-off overrides the per-beat draw
      if (hold_off > 0) begin
        hold_off   <= hold_off - 1;
        out_stall  <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        out_stall  <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || expected_blocks.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one key register while the block is idle; hold until it is taken.
  task automatic write_key(cfg_reg_t idx, logic [63:0] value);
    cfg_index <= 1'(idx);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CfgKeyHigh) model_key_hi = value;
    else model_key_lo = value;
    expand_schedule();
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_block(logic dec, logic [63:0] hi, logic [63:0] lo);
    pending_blocks.push_back('{dec: dec, hi: hi, lo: lo});
  endtask

  // Random blocks with a random operation; some have an all-zero or all-ones high half.
  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      case ($urandom_range(0, 3))
        0: queue_block(1'($urandom_range(0, 1)), 64'h0, rand64());
        1: queue_block(1'($urandom_range(0, 1)), 64'hffff_ffff_ffff_ffff, rand64());
        default: queue_block(1'($urandom_range(0, 1)), rand64(), rand64());
      endcase
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = 1'b0;
    block_high = '0;
    block_low = '0;
    out_stall = 1'b0;
    fail_count = 0;
    hold_off = 0;
    model_key_hi = '0;
    model_key_lo = '0;
    build_sboxes();
    expand_schedule();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the all-zero reset key, extremes of the block, both operations.
    queue_block(1'b0, 64'h0, 64'h0);
    queue_block(1'b1, 64'h0, 64'h0);
    queue_block(1'b0, '1, '1);
    queue_block(1'b1, '1, '1);
    queue_block(1'b0, 64'h8000_0000_0000_0000, 64'h1);
    wait_drained();

    // FIPS-197 example key, plus its known plaintext and ciphertext.
    write_key(CfgKeyHigh, 64'h0001_0203_0405_0607);
    write_key(CfgKeyLow, 64'h0809_0a0b_0c0d_0e0f);
    queue_block(1'b0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    queue_block(1'b1, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    queue_block(1'b0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    queue_block(1'b1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    wait_drained();

    // All-ones key; only one half changed first, so the mixed key is used too.
    write_key(CfgKeyHigh, '1);
    queue_block(1'b0, 64'h0, 64'h0);
    queue_block(1'b1, 64'h0, 64'h0);
    wait_drained();
    write_key(CfgKeyLow, '1);
    queue_block(1'b0, '1, 64'h0);
    queue_block(1'b1, 64'h0, '1);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering: fill the block.
    hold_off = 200;
    queue_random(20);
    wait_drained();

    // Random phases under a series of keys; pause for a full drain between them.
    for (int phase = 0; phase < 6; phase++) begin
      write_key(CfgKeyHigh, rand64());
      write_key(CfgKeyLow, rand64());
      queue_random(100);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
